### hw/rtl/dbs_pkg.sv
// Shared types and constants for the delayed bucket scatter block.
// No dependencies; imported by the top level.
package dbs_pkg;

   // Most writes a single flush item may produce
   localparam int MAX_WRITES = 16;
   localparam int WRITE_COUNT_BITS = $clog2(MAX_WRITES + 1);

   // Bucket field on the input channel
   localparam int BUCKET_FIELD_BITS = 4;
   localparam int BUCKET_FIELD_CODES = 2 ** BUCKET_FIELD_BITS;

   // Payload field widths on the channels
   localparam int DATA_FIELD_BITS = 64;
   localparam int ADDR_FIELD_BITS = 16;
   localparam int REQ_TDATA_BITS = 104;
   localparam int RSP_TDATA_BITS = 88;

   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_FLUSH  = 2'd1,
      MODE_WINDOW = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_LIMIT = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_SEND
   } state_type;

endpackage

### hw/rtl/dbs_window_mem.sv
// Per-bucket window table: next-slot pointer and slot limit for each bucket.
// One write port, one registered read port; valid bits make unwritten rows read as zero.
module dbs_window_mem #(
   parameter int NUM_BUCKETS = 16,
   parameter int ADDR_BITS   = 16,
   parameter int BUCKET_BITS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [BUCKET_BITS-1:0] wr_index,
   input  logic [ADDR_BITS-1:0]   wr_next,
   input  logic [ADDR_BITS-1:0]   wr_limit,
   input  logic [BUCKET_BITS-1:0] rd_index,
   output logic [ADDR_BITS-1:0]   rd_next,
   output logic [ADDR_BITS-1:0]   rd_limit
);

   logic [2*ADDR_BITS-1:0] window_mem [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0] row_valid_ff;
   logic [NUM_BUCKETS-1:0] row_valid_in;
   logic [2*ADDR_BITS-1:0] rd_word_ff;
   logic                   rd_valid_ff;

   always_comb begin
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[wr_index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= row_valid_ff[rd_index];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         window_mem[wr_index] <= {wr_limit, wr_next};
      end
      rd_word_ff <= window_mem[rd_index];
   end

   // A row never written reads as a zero window
   assign rd_next  = rd_valid_ff ? rd_word_ff[ADDR_BITS-1:0] : '0;
   assign rd_limit = rd_valid_ff ? rd_word_ff[2*ADDR_BITS-1:ADDR_BITS] : '0;

endmodule

### hw/rtl/delayed_bucket_scatter_top.sv
// Delayed bucket scatter: items pass through a delay ring of CAPACITY entries and are
// written to per-bucket slot windows once the ring overflows or is flushed.
// Depends on dbs_pkg and dbs_window_mem.
//
// One item is worked on at a time; req_tready is high only while the block is idle.
// A push into a ring that is not full, a window set and a flush of an empty ring go
// straight from accept to the result register. A push into a full ring and each write
// of a flush (at most 16 per flush item) run through the single update path, and a
// result is held while rsp_tready is low. The update path is a registered read of the
// ring, then a registered read of the bucket window table, then the pointer increment
// and limit compare, then the result register. The window table resets through per-row
// valid bits, so no clearing pass is needed after reset.
module delayed_bucket_scatter_top
   import dbs_pkg::*;
#(
   parameter int CAPACITY    = 16,
   parameter int NUM_BUCKETS = 16,
   parameter int ITEM_BITS   = 64,
   parameter int ADDR_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // req_tdata: item_data[63:0], bucket[67:64], window_start[83:68],
   //            window_limit[99:84], zero pad[103:100]
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // req_tuser: mode[1:0]
   input  logic [1:0]                req_tuser,
   // rsp_tdata: write_valid[0], write_data[64:1], write_address[80:65],
   //            write_bucket[84:81], status[86:85], zero pad[87]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                      rsp_tlast
);

   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(2 * CAPACITY);
   localparam int KW = WRITE_COUNT_BITS;

   // ---------------- input fields
   mode_type                     req_mode;
   logic [DATA_FIELD_BITS-1:0]   req_item_data;
   logic [BUCKET_FIELD_BITS-1:0] req_bucket;
   logic [ADDR_FIELD_BITS-1:0]   req_window_start;
   logic [ADDR_FIELD_BITS-1:0]   req_window_limit;
   logic                         req_accept;
   logic                         rsp_accept;

   assign req_mode         = mode_type'(req_tuser);
   assign req_item_data    = req_tdata[63:0];
   assign req_bucket       = req_tdata[67:64];
   assign req_window_start = req_tdata[83:68];
   assign req_window_limit = req_tdata[99:84];

   // bucket modulo NUM_BUCKETS over every code of the input field
   logic [BW-1:0] bucket_mod [BUCKET_FIELD_CODES];
   for (genvar g = 0; g < BUCKET_FIELD_CODES; g++) begin : g_bucket_mod
      assign bucket_mod[g] = BW'(g % NUM_BUCKETS);
   end

   logic [BW-1:0] req_bucket_mod;
   assign req_bucket_mod = bucket_mod[req_bucket];

   // ---------------- registers
   state_type            state_ff, state_in;
   logic [CW-1:0]        pushed_ff, pushed_in;
   logic [CW-1:0]        written_ff, written_in;
   logic [ITEM_BITS-1:0] item_ff, item_in;
   logic [BW-1:0]        item_bucket_ff, item_bucket_in;
   logic                 is_flush_ff, is_flush_in;
   logic [KW-1:0]        count_ff, count_in;
   logic [KW-1:0]        write_total_ff, write_total_in;
   logic                 out_valid_ff, out_valid_in;
   logic [ITEM_BITS-1:0] out_data_ff, out_data_in;
   logic [ADDR_BITS-1:0] out_addr_ff, out_addr_in;
   logic [BW-1:0]        out_bucket_ff, out_bucket_in;
   status_type           out_status_ff, out_status_in;
   logic                 out_last_ff, out_last_in;

   // ---------------- ring occupancy and slots
   logic [CW:0]   occ_wide;
   logic [CW-1:0] occupancy;
   logic          ring_full;
   logic          ring_empty;
   logic [CW-1:0] push_slot_full;
   logic [CW-1:0] write_slot_full;
   logic [SW-1:0] push_slot;
   logic [SW-1:0] write_slot;
   logic [CW-1:0] pushed_inc;
   logic [CW-1:0] written_inc;

   always_comb begin
      if (pushed_ff >= written_ff) begin
         occ_wide = {1'b0, pushed_ff} - {1'b0, written_ff};
      end else begin
         occ_wide = {1'b0, pushed_ff} + (CW+1)'(2 * CAPACITY) - {1'b0, written_ff};
      end
   end

   assign occupancy  = CW'(occ_wide);
   assign ring_full  = (occupancy >= CW'(CAPACITY));
   assign ring_empty = (occupancy == '0);

   assign push_slot_full  = (pushed_ff >= CW'(CAPACITY)) ? pushed_ff - CW'(CAPACITY)
                                                         : pushed_ff;
   assign write_slot_full = (written_ff >= CW'(CAPACITY)) ? written_ff - CW'(CAPACITY)
                                                          : written_ff;
   assign push_slot  = push_slot_full[SW-1:0];
   assign write_slot = write_slot_full[SW-1:0];

   assign pushed_inc  = (pushed_ff == CW'(2 * CAPACITY - 1)) ? '0 : pushed_ff + 1'b1;
   assign written_inc = (written_ff == CW'(2 * CAPACITY - 1)) ? '0 : written_ff + 1'b1;

   // ---------------- delay ring memory
   logic [BW+ITEM_BITS-1:0] ring_mem [CAPACITY];
   logic [BW+ITEM_BITS-1:0] ring_q_ff;
   logic                    ring_wr_en;
   logic [ITEM_BITS-1:0]    ring_wr_data;
   logic [BW-1:0]           ring_wr_bucket;
   logic [ITEM_BITS-1:0]    ring_q_data;
   logic [BW-1:0]           ring_q_bucket;

   // Read the oldest entry every cycle; it is stable by the time it is used
   always_ff @(posedge clock) begin
      if (ring_wr_en) begin
         ring_mem[push_slot] <= {ring_wr_bucket, ring_wr_data};
      end
      ring_q_ff <= ring_mem[write_slot];
   end

   assign ring_q_data   = ring_q_ff[ITEM_BITS-1:0];
   assign ring_q_bucket = ring_q_ff[BW+ITEM_BITS-1:ITEM_BITS];

   // ---------------- bucket window table
   logic                 win_wr_en;
   logic [BW-1:0]        win_wr_index;
   logic [ADDR_BITS-1:0] win_wr_next;
   logic [ADDR_BITS-1:0] win_wr_limit;
   logic [ADDR_BITS-1:0] win_rd_next;
   logic [ADDR_BITS-1:0] win_rd_limit;

   dbs_window_mem #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .ADDR_BITS   (ADDR_BITS),
      .BUCKET_BITS (BW)
   ) u_window_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (win_wr_en),
      .wr_index (win_wr_index),
      .wr_next  (win_wr_next),
      .wr_limit (win_wr_limit),
      .rd_index (ring_q_bucket),
      .rd_next  (win_rd_next),
      .rd_limit (win_rd_limit)
   );

   // ---------------- shared pointer update
   logic [ADDR_BITS-1:0] next_pointer;
   logic                 limit_hit;
   logic                 flush_done;

   assign next_pointer = win_rd_next + 1'b1;
   assign limit_hit    = !(next_pointer < win_rd_limit);
   assign flush_done   = limit_hit || (KW'(count_ff + 1'b1) == write_total_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_mode)
                  MODE_PUSH:   state_in = ring_full ? ST_FETCH : ST_SEND;
                  MODE_FLUSH:  state_in = ring_empty ? ST_SEND : ST_FETCH;
                  MODE_WINDOW: state_in = ST_SEND;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_accept) begin
               state_in = (is_flush_ff && !out_last_ff) ? ST_FETCH : ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath and memory controls
   always_comb begin
      pushed_in      = pushed_ff;
      written_in     = written_ff;
      item_in        = item_ff;
      item_bucket_in = item_bucket_ff;
      is_flush_in    = is_flush_ff;
      count_in       = count_ff;
      write_total_in = write_total_ff;
      out_valid_in   = out_valid_ff;
      out_data_in    = out_data_ff;
      out_addr_in    = out_addr_ff;
      out_bucket_in  = out_bucket_ff;
      out_status_in  = out_status_ff;
      out_last_in    = out_last_ff;
      ring_wr_en     = 1'b0;
      ring_wr_data   = ITEM_BITS'(req_item_data);
      ring_wr_bucket = req_bucket_mod;
      win_wr_en      = 1'b0;
      win_wr_index   = req_bucket_mod;
      win_wr_next    = ADDR_BITS'(req_window_start);
      win_wr_limit   = ADDR_BITS'(req_window_limit);

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               is_flush_in   = 1'b0;
               out_valid_in  = 1'b0;
               out_data_in   = '0;
               out_addr_in   = '0;
               out_bucket_in = '0;
               out_status_in = STATUS_OK;
               out_last_in   = 1'b1;
               case (req_mode)
                  MODE_PUSH: begin
                     item_in        = ITEM_BITS'(req_item_data);
                     item_bucket_in = req_bucket_mod;
                     // store now unless the oldest entry must be written out first
                     if (!ring_full) begin
                        ring_wr_en = 1'b1;
                        pushed_in  = pushed_inc;
                     end
                  end
                  MODE_FLUSH: begin
                     if (ring_empty) begin
                        out_status_in = STATUS_EMPTY;
                     end else begin
                        is_flush_in = 1'b1;
                        count_in    = '0;
                        if (int'(occupancy) > MAX_WRITES) begin
                           write_total_in = KW'(MAX_WRITES);
                        end else begin
                           write_total_in = KW'(occupancy);
                        end
                     end
                  end
                  MODE_WINDOW: begin
                     win_wr_en = 1'b1;
                  end
                  default: begin
                     is_flush_in = 1'b0;
                  end
               endcase
            end
         end
         ST_UPDATE: begin
            win_wr_en     = 1'b1;
            win_wr_index  = ring_q_bucket;
            win_wr_next   = next_pointer;
            win_wr_limit  = win_rd_limit;
            written_in    = written_inc;
            out_valid_in  = 1'b1;
            out_data_in   = ring_q_data;
            out_addr_in   = win_rd_next;
            out_bucket_in = ring_q_bucket;
            out_status_in = limit_hit ? STATUS_LIMIT : STATUS_OK;
            out_last_in   = is_flush_ff ? flush_done : 1'b1;
            // a push into a full ring takes the slot just freed
            if (!is_flush_ff) begin
               ring_wr_en     = 1'b1;
               ring_wr_data   = item_ff;
               ring_wr_bucket = item_bucket_ff;
               pushed_in      = pushed_inc;
            end
         end
         ST_SEND: begin
            if (rsp_accept && is_flush_ff && !out_last_ff) begin
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pushed_ff   <= '0;
         written_ff  <= '0;
         is_flush_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         pushed_ff   <= pushed_in;
         written_ff  <= written_in;
         is_flush_ff <= is_flush_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      item_bucket_ff <= item_bucket_in;
      write_total_ff <= write_total_in;
      out_valid_ff   <= out_valid_in;
      out_data_ff    <= out_data_in;
      out_addr_ff    <= out_addr_in;
      out_bucket_ff  <= out_bucket_in;
      out_status_ff  <= out_status_in;
      out_last_ff    <= out_last_in;
   end

   // ---------------- result channel
   assign rsp_tdata = {1'b0,
                       out_status_ff,
                       BUCKET_FIELD_BITS'(out_bucket_ff),
                       ADDR_FIELD_BITS'(out_addr_ff),
                       DATA_FIELD_BITS'(out_data_ff),
                       out_valid_ff};
   assign rsp_tlast = out_last_ff;

   // ---------------- assertions
   a_send_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted while a result is pending");

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      int'(occupancy) <= CAPACITY)
      else $error("ring occupancy above capacity");

   a_update_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> (written_ff != $past(written_ff)))
      else $error("write count did not advance after an update");

   a_flush_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH && is_flush_ff) |-> (count_ff < write_total_ff))
      else $error("flush wrote more items than it was allowed");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for delayed_bucket_scatter_top. A directed table runs first, then
// random pushes, flushes and window sets, all checked against an in-bench scatter predictor.
// Depends on dbs_pkg and the RTL of the block.
module tb_top
   import dbs_pkg::*;
();

   localparam int RING_DEPTH      = 16;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_CYCLES     = 300;
   localparam int ITEMS_PER_PHASE = 40;
   localparam int TAIL_CYCLES     = 64;

   typedef struct {
      mode_type    mode;
      logic [63:0] data;
      logic [3:0]  bucket;
      logic [15:0] wstart;
      logic [15:0] wlimit;
   } scatter_req_type;

   typedef struct {
      logic        wvalid;
      logic [63:0] wdata;
      logic [15:0] waddr;
      logic [3:0]  wbucket;
      status_type  status;
      logic        last;
   } scatter_result_type;

   typedef struct {
      scatter_req_type req;
      bit              typed;
      status_type      status;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic [1:0]                req_tuser = 2'b00;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tlast;

   // Predictor state
   logic [63:0] ring_item [RING_DEPTH];
   logic [3:0]  ring_bucket [RING_DEPTH];
   logic [4:0]  pushed_total;
   logic [4:0]  written_total;
   logic [15:0] next_slot [BUCKET_FIELD_CODES];
   logic [15:0] slot_limit [BUCKET_FIELD_CODES];

   scatter_result_type due_results[$];
   stim_row_type       directed_rows[$];
   scatter_result_type head_result;
   int                 mismatches = 0;
   int                 cycle_count = 0;
   int                 tx_idle_pct = 0;
   int                 rx_idle_pct = 0;
   bit                 hold_request = 1'b0;
   bit                 hold_seen = 1'b0;
   int                 hold_left = 0;

   delayed_bucket_scatter_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic scatter_result_type idle_result(status_type st);
      scatter_result_type r;
      r.wvalid  = 1'b0;
      r.wdata   = 64'd0;
      r.waddr   = 16'd0;
      r.wbucket = 4'd0;
      r.status  = st;
      r.last    = 1'b1;
      return r;
   endfunction

   // Write the oldest ring item to its bucket and advance that bucket's pointer
   function automatic scatter_result_type evict_oldest();
      scatter_result_type r;
      logic [3:0]         b;
      logic [15:0]        advanced;
      b = ring_bucket[written_total[3:0]];
      advanced = next_slot[b] + 16'd1;
      r.wvalid  = 1'b1;
      r.wdata   = ring_item[written_total[3:0]];
      r.waddr   = next_slot[b];
      r.wbucket = b;
      r.status  = (advanced < slot_limit[b]) ? STATUS_OK : STATUS_LIMIT;
      r.last    = 1'b1;
      next_slot[b] = advanced;
      written_total = written_total + 5'd1;
      return r;
   endfunction

   function automatic void scatter_step(scatter_req_type req,
                                        ref scatter_result_type produced[$]);
      logic [4:0]         fill;
      int                 n;
      scatter_result_type r;
      fill = pushed_total - written_total;
      case (req.mode)
         MODE_PUSH: begin
            if (fill >= 5'(RING_DEPTH))
               produced.push_back(evict_oldest());
            else
               produced.push_back(idle_result(STATUS_OK));
            ring_item[pushed_total[3:0]] = req.data;
            ring_bucket[pushed_total[3:0]] = req.bucket;
            pushed_total = pushed_total + 5'd1;
         end
         MODE_FLUSH: begin
            if (fill == 5'd0) begin
               produced.push_back(idle_result(STATUS_EMPTY));
            end else begin
               n = (int'(fill) > MAX_WRITES) ? MAX_WRITES : int'(fill);
               for (int k = 0; k < n; k++) begin
                  r = evict_oldest();
                  r.last = (r.status == STATUS_LIMIT) || (k + 1 == n);
                  produced.push_back(r);
                  if (r.status == STATUS_LIMIT) break;
               end
            end
         end
         MODE_WINDOW: begin
            next_slot[req.bucket] = req.wstart;
            slot_limit[req.bucket] = req.wlimit;
            produced.push_back(idle_result(STATUS_OK));
         end
         default: ;
      endcase
   endfunction

   function automatic scatter_req_type random_req();
      scatter_req_type req;
      int              pick;
      pick = $urandom_range(0, 99);
      req.data = {$urandom, $urandom};
      // favor a few buckets so their windows get set and their pointers climb
      req.bucket = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                               : 4'($urandom_range(0, 15));
      req.wstart = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      req.wlimit = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                               : req.wstart + 16'($urandom_range(0, 24));
      if (pick < 60)
         req.mode = MODE_PUSH;
      else if (pick < 78)
         req.mode = MODE_FLUSH;
      else if (pick < 95)
         req.mode = MODE_WINDOW;
      else
         req.mode = MODE_UNUSED;
      return req;
   endfunction

   task automatic add_row(mode_type mode, logic [63:0] data, logic [3:0] bucket,
                          logic [15:0] wstart, logic [15:0] wlimit, bit typed, status_type st);
      stim_row_type row;
      row.req.mode   = mode;
      row.req.data   = data;
      row.req.bucket = bucket;
      row.req.wstart = wstart;
      row.req.wlimit = wlimit;
      row.typed      = typed;
      row.status     = st;
      directed_rows.push_back(row);
   endtask

   task automatic send_item(scatter_req_type req, bit typed, status_type typed_status);
      scatter_result_type produced[$];
      req_tvalid <= 1'b1;
      req_tuser  <= req.mode;
      req_tdata  <= {4'd0, req.wlimit, req.wstart, req.bucket, req.data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scatter_step(req, produced);
      if (typed)
         due_results.push_back(idle_result(typed_status));
      else
         foreach (produced[i]) due_results.push_back(produced[i]);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Ignored items do not count toward the phase
   task automatic run_random(int count);
      scatter_req_type req;
      int              counted;
      counted = 0;
      while (counted < count) begin
         req = random_req();
         send_item(req, 1'b0, STATUS_OK);
         if (req.mode != MODE_UNUSED) counted++;
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // Receiver: random back-pressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen  <= hold_request;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected item, expected none actual %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            head_result = due_results.pop_front();
            check_field("write_valid", 64'(head_result.wvalid), 64'(rsp_tdata[0]));
            check_field("write_data", head_result.wdata, rsp_tdata[64:1]);
            check_field("write_address", 64'(head_result.waddr), 64'(rsp_tdata[80:65]));
            check_field("write_bucket", 64'(head_result.wbucket), 64'(rsp_tdata[84:81]));
            check_field("status", 64'(head_result.status), 64'(rsp_tdata[86:85]));
            check_field("last", 64'(head_result.last), 64'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      pushed_total  = 5'd0;
      written_total = 5'd0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         ring_item[i]   = 64'd0;
         ring_bucket[i] = 4'd0;
      end
      for (int i = 0; i < BUCKET_FIELD_CODES; i++) begin
         next_slot[i]  = 16'd0;
         slot_limit[i] = 16'd0;
      end

      add_row(MODE_FLUSH, 64'd0, 4'd0, 16'h0000, 16'h0000, 1'b1, STATUS_EMPTY);
      add_row(MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 16'hFFFF, 16'hFFFF, 1'b0, STATUS_OK);
      // bucket 15 sits at the top of the address space, so its first write wraps
      add_row(MODE_WINDOW, 64'd0, 4'd15, 16'hFFFF, 16'h0000, 1'b1, STATUS_OK);
      add_row(MODE_WINDOW, 64'd0, 4'd5, 16'h000A, 16'h000C, 1'b1, STATUS_OK);
      add_row(MODE_WINDOW, 64'd0, 4'd0, 16'h0000, 16'hFFFF, 1'b1, STATUS_OK);
      // fill the ring; nothing is written out yet
      for (int i = 0; i < RING_DEPTH; i++)
         add_row(MODE_PUSH,
                 (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : ((i == 1) ? 64'd0 : {$urandom, $urandom}),
                 (i == 0) ? 4'd15 : ((i < 3) ? 4'd5 : 4'(i)),
                 16'($urandom), 16'($urandom), 1'b1, STATUS_OK);
      add_row(MODE_PUSH, 64'd0, 4'd15, 16'h0000, 16'h0000, 1'b0, STATUS_OK);
      add_row(MODE_FLUSH, 64'd0, 4'd0, 16'h0000, 16'h0000, 1'b0, STATUS_OK);
      add_row(MODE_FLUSH, 64'd0, 4'd0, 16'h0000, 16'h0000, 1'b0, STATUS_OK);
      add_row(MODE_FLUSH, 64'd0, 4'd0, 16'h0000, 16'h0000, 1'b0, STATUS_OK);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 7;
      rx_idle_pct = 61;
      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].status);
      drain_results();

      // receiver holds off while the sender keeps offering items
      hold_request = ~hold_request;
      run_random(ITEMS_PER_PHASE);
      drain_results();

      tx_idle_pct = 61;
      rx_idle_pct = 7;
      run_random(ITEMS_PER_PHASE);
      drain_results();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_random(ITEMS_PER_PHASE);
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
